// ===== rtl/core/bqd_pkg.sv =====
// Shared types and constants for the biquad IIR filter.
// Used by the channel interfaces, the sequencer, coefficient bank and top level.
package bqd_pkg;

  // Coefficient format is fixed at 24 bits (Q2.22 by default)
  localparam int COEF_W     = 24;
  localparam int CFG_IDX_W  = 3;
  // Term counter: four feedback terms, then six feedforward terms
  localparam int TERM_CNT_W = 4;
  localparam int FB_TERMS   = 4;
  localparam int ALL_TERMS  = 10;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t B0_RESET = 24'sd4194304;

  // Register map of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0 = 3'd0,
    REG_FF1 = 3'd1,
    REG_FF2 = 3'd2,
    REG_FB1 = 3'd3,
    REG_FB2 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  typedef enum logic [2:0] {
    CSEL_B0,
    CSEL_B1,
    CSEL_B2,
    CSEL_A1,
    CSEL_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    VSEL_W1,
    VSEL_W2,
    VSEL_W
  } val_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_DRAIN,
    ST_CALC_W,
    ST_FF,
    ST_FF_DRAIN,
    ST_CALC_Y
  } state_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic      in_ready;
    logic      issue;
    coef_sel_t coef_sel;
    val_sel_t  val_sel;
    logic      hi;
    logic      acc_clear;
    logic      load_w;
    logic      load_y;
  } ctrl_t;

endpackage

// ===== rtl/core/bqd_if.sv =====
// Channel interfaces of the biquad filter: sample in, sample out, config writes.
// Depends on bqd_pkg for the register index and coefficient widths.
interface bqd_in_if #(parameter int WIDTH = 24) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface bqd_out_if #(parameter int WIDTH = 24) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface bqd_cfg_if import bqd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bqd_coef_regs.sv =====
// Coefficient register bank written over the configuration channel.
// Depends on bqd_pkg (coef_set_t, register map).
module bqd_coef_regs import bqd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COEF_W-1:0]    wr_data,
  output coef_set_t            coefs
);

  // Unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_FF0: coefs.b0 <= coef_t'(wr_data);
        REG_FF1: coefs.b1 <= coef_t'(wr_data);
        REG_FF2: coefs.b2 <= coef_t'(wr_data);
        REG_FB1: coefs.a1 <= coef_t'(wr_data);
        REG_FB2: coefs.a2 <= coef_t'(wr_data);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/bqd_mac.sv =====
// Shared multiply-accumulate unit: one coefficient times one half of a state word.
// Depends on bqd_pkg (coef_t). Product is registered before accumulation.
module bqd_mac import bqd_pkg::*; #(
  parameter  int STATE_WIDTH    = 32,
  parameter  int COEF_FRAC_BITS = 22,
  localparam int ACC_W          = COEF_W + STATE_WIDTH + 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    issue,
  input  logic                    hi,
  input  logic                    clear,
  input  coef_t                   coef,
  input  logic [STATE_WIDTH-1:0]  val,
  output logic signed [ACC_W-1:0] acc
);

  localparam int LO_W   = STATE_WIDTH / 2;
  localparam int HI_W   = STATE_WIDTH - LO_W;
  localparam int OPB_W  = HI_W + 1;
  localparam int PROD_W = COEF_W + OPB_W;
  localparam logic signed [ACC_W-1:0] ROUND =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  addend;
  logic                     prod_vld;
  logic                     prod_hi;

  // Low half is unsigned, high half carries the sign
  always_comb begin
    if (hi) begin
      opb = {val[STATE_WIDTH-1], val[STATE_WIDTH-1:LO_W]};
    end else begin
      opb = {{(OPB_W-LO_W){1'b0}}, val[LO_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod    <= coef * opb;
      prod_hi <= hi;
    end
  end

  // High-half products weigh 2^LO_W
  always_comb begin
    if (prod_hi) begin
      addend = ACC_W'(prod) <<< LO_W;
    end else begin
      addend = ACC_W'(prod);
    end
  end

  // Accumulator starts at the rounding offset
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= ROUND;
    end else if (prod_vld) begin
      acc <= acc + addend;
    end
  end

endmodule

// ===== rtl/core/bqd_ctrl.sv =====
// Sequencer: walks the ten product terms through the shared MAC unit.
// Depends on bqd_pkg (state_t, ctrl_t and term counts).
module bqd_ctrl import bqd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_busy,
  output ctrl_t ctrl
);

  state_t                state;
  state_t                state_next;
  logic [TERM_CNT_W-1:0] cnt;
  logic [TERM_CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = ST_FB;
      end
      ST_FB: begin
        cnt_next = cnt + 1'b1;
        if (cnt == TERM_CNT_W'(FB_TERMS - 1)) state_next = ST_FB_DRAIN;
      end
      ST_FB_DRAIN: state_next = ST_CALC_W;
      ST_CALC_W:   state_next = ST_FF;
      ST_FF: begin
        cnt_next = cnt + 1'b1;
        if (cnt == TERM_CNT_W'(ALL_TERMS - 1)) state_next = ST_FF_DRAIN;
      end
      ST_FF_DRAIN: state_next = ST_CALC_Y;
      ST_CALC_Y: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl.in_ready  = 1'b0;
    ctrl.issue     = 1'b0;
    ctrl.acc_clear = 1'b0;
    ctrl.load_w    = 1'b0;
    ctrl.load_y    = 1'b0;
    ctrl.hi        = cnt[0];
    unique case (state)
      ST_IDLE: begin
        ctrl.in_ready  = 1'b1;
        ctrl.acc_clear = 1'b1;
      end
      ST_FB, ST_FF: ctrl.issue = 1'b1;
      ST_CALC_W: begin
        ctrl.load_w    = 1'b1;
        ctrl.acc_clear = 1'b1;
      end
      ST_CALC_Y: ctrl.load_y = !out_busy;
      default: ;
    endcase

    // Term pair: a1*w1, a2*w2, b0*w, b1*w1, b2*w2
    unique case (cnt[TERM_CNT_W-1:1])
      3'd0: begin
        ctrl.coef_sel = CSEL_A1;
        ctrl.val_sel  = VSEL_W1;
      end
      3'd1: begin
        ctrl.coef_sel = CSEL_A2;
        ctrl.val_sel  = VSEL_W2;
      end
      3'd2: begin
        ctrl.coef_sel = CSEL_B0;
        ctrl.val_sel  = VSEL_W;
      end
      3'd3: begin
        ctrl.coef_sel = CSEL_B1;
        ctrl.val_sel  = VSEL_W1;
      end
      3'd4: begin
        ctrl.coef_sel = CSEL_B2;
        ctrl.val_sel  = VSEL_W2;
      end
      default: begin
        ctrl.coef_sel = CSEL_B0;
        ctrl.val_sel  = VSEL_W;
      end
    endcase
  end

endmodule

// ===== rtl/core/biquad_iir_filter.sv =====
// Biquad IIR filter, direct form II, fixed point, on one shared multiplier.
// Each request takes ten passes through the shared 24 x (STATE_WIDTH/2+1) multiplier
// plus two drain and two saturate steps; a new request is taken only once the result
// is stored and the block is back in idle, which an output stall can hold off.
// Reset (rst, synchronous): b0 = 1.0, other coefficients and both delays zero,
// output register empty. Depends on bqd_pkg, bqd_if, bqd_coef_regs, bqd_mac, bqd_ctrl.
module biquad_iir_filter import bqd_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 22,
  parameter int STATE_WIDTH    = 32
) (
  input  logic     clk,
  input  logic     rst,
  bqd_cfg_if.sink  cfg,
  bqd_in_if.sink   in_chan,
  bqd_out_if.source out_chan
);

  localparam int ACC_W = COEF_W + STATE_WIDTH + 3;
  localparam int EXT_W = ACC_W + 1;
  localparam logic signed [EXT_W-1:0] ST_MAX =
    {{(EXT_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [ACC_W-1:0] SMP_MAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;

  ctrl_t                          ctrl;
  coef_set_t                      coefs;
  coef_t                          coef_op;
  logic [STATE_WIDTH-1:0]         val_op;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        sum_shr;
  logic signed [EXT_W-1:0]        diff;
  logic signed [STATE_WIDTH-1:0]  w_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [STATE_WIDTH-1:0]  w_reg;
  logic signed [STATE_WIDTH-1:0]  delay_one;
  logic signed [STATE_WIDTH-1:0]  delay_two;
  logic signed [SAMPLE_WIDTH-1:0] y_reg;
  logic                           y_vld;
  logic                           out_busy;

  // Configuration is taken at any time
  assign cfg.ready = 1'b1;

  bqd_coef_regs u_coef_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .coefs    (coefs)
  );

  assign out_busy = y_vld && !out_chan.ready;

  bqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  assign in_chan.ready = ctrl.in_ready;

  // Capture the request sample
  always_ff @(posedge clk) begin
    if (in_chan.valid && ctrl.in_ready) begin
      x_reg <= in_chan.sample_in;
    end
  end

  // Operand selection for the shared MAC
  always_comb begin
    unique case (ctrl.coef_sel)
      CSEL_B0: coef_op = coefs.b0;
      CSEL_B1: coef_op = coefs.b1;
      CSEL_B2: coef_op = coefs.b2;
      CSEL_A1: coef_op = coefs.a1;
      CSEL_A2: coef_op = coefs.a2;
      default: coef_op = coefs.b0;
    endcase
    unique case (ctrl.val_sel)
      VSEL_W1: val_op = delay_one;
      VSEL_W2: val_op = delay_two;
      VSEL_W:  val_op = w_reg;
      default: val_op = w_reg;
    endcase
  end

  bqd_mac #(
    .STATE_WIDTH    (STATE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (ctrl.issue),
    .hi    (ctrl.hi),
    .clear (ctrl.acc_clear),
    .coef  (coef_op),
    .val   (val_op),
    .acc   (acc)
  );

  // Rounded sum: offset was preloaded, floor by arithmetic shift
  assign sum_shr = acc >>> COEF_FRAC_BITS;
  assign diff    = EXT_W'(x_reg) - EXT_W'(sum_shr);

  // Saturate internal value and output
  always_comb begin
    if (diff > ST_MAX) begin
      w_sat = ST_MAX[STATE_WIDTH-1:0];
    end else if (diff < ST_MIN) begin
      w_sat = ST_MIN[STATE_WIDTH-1:0];
    end else begin
      w_sat = diff[STATE_WIDTH-1:0];
    end
    if (sum_shr > SMP_MAX) begin
      y_sat = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (sum_shr < SMP_MIN) begin
      y_sat = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = sum_shr[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_w) begin
      w_reg <= w_sat;
    end
  end

  // Delay line shifts once the result is stored
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (ctrl.load_y) begin
      delay_two <= delay_one;
      delay_one <= w_reg;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      y_vld <= 1'b0;
    end else if (ctrl.load_y) begin
      y_vld <= 1'b1;
    end else if (out_chan.ready) begin
      y_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_y) begin
      y_reg <= y_sat;
    end
  end

  assign out_chan.valid      = y_vld;
  assign out_chan.sample_out = y_reg;

endmodule

// ===== rtl/core/bqd_checker.sv =====
// Port-level checks for the biquad filter, attached by bind.
// Depends on biquad_iir_filter port names only.
module bqd_port_checks #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sample_out))
    else $error("result changed while stalled");

  // One request at a time: ready drops once a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("request taken while busy");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind biquad_iir_filter bqd_port_checks #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqd_port_checks (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .sample_out (out_chan.sample_out)
);

// ===== test/bqd_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the biquad IIR filter: tracks coefficient writes, predicts every
// filtered sample and compares it with the output channel in order.
// Depends on bqd_pkg and the channel interfaces of bqd_if.
module bqd_checker import bqd_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 22,
  parameter int STATE_WIDTH    = 32
) (
  input  logic clk,
  input  logic rst,
  bqd_cfg_if   cfg_mon,
  bqd_in_if    in_mon,
  bqd_out_if   out_mon,
  output int   mismatches,
  output int   pending
);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [STATE_WIDTH-1:0]  delay_t;

  coef_set_t coefs;
  delay_t    w1_delay;
  delay_t    w2_delay;
  sample_t   sample_out_due [$];

  // Divide a coefficient-weighted sum by 2^COEF_FRAC_BITS, rounding half up
  function automatic longint round_coef_sum(input longint acc);
    return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp_to_width(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One direct form II step: new internal value, output, then shift the delays
  function automatic sample_t predict_sample_out(input sample_t x);
    longint fb;
    longint w;
    longint y;
    fb = round_coef_sum(longint'(coefs.a1) * longint'(w1_delay)
                      + longint'(coefs.a2) * longint'(w2_delay));
    w  = clamp_to_width(longint'(x) - fb, STATE_WIDTH);
    y  = round_coef_sum(longint'(coefs.b0) * w
                      + longint'(coefs.b1) * longint'(w1_delay)
                      + longint'(coefs.b2) * longint'(w2_delay));
    y  = clamp_to_width(y, SAMPLE_WIDTH);
    w2_delay = w1_delay;
    w1_delay = delay_t'(w);
    return sample_t'(y);
  endfunction

  // Sample all three channels at the rising edge
  always @(posedge clk) begin : watch_channels
    sample_t expected_out;
    if (rst) begin
      coefs    = '0;
      coefs.b0 = B0_RESET;
      w1_delay = '0;
      w2_delay = '0;
      sample_out_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          REG_FF0: coefs.b0 = coef_t'(cfg_mon.data);
          REG_FF1: coefs.b1 = coef_t'(cfg_mon.data);
          REG_FF2: coefs.b2 = coef_t'(cfg_mon.data);
          REG_FB1: coefs.a1 = coef_t'(cfg_mon.data);
          REG_FB2: coefs.a2 = coef_t'(cfg_mon.data);
          default: ; // unmapped index, write dropped
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (sample_out_due.size() == 0) begin
          $error("sample_out: expected none, actual %0d", out_mon.sample_out);
          mismatches++;
        end else begin
          expected_out = sample_out_due.pop_front();
          if (out_mon.sample_out !== expected_out) begin
            $error("sample_out: expected %0d, actual %0d", expected_out,
                   out_mon.sample_out);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        sample_out_due.push_back(predict_sample_out(in_mon.sample_in));
    end
    pending = sample_out_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for biquad_iir_filter: clock, reset, coefficient writes, sample
// stimulus with random gaps and output stalls, watchdog and verdict.
// Depends on bqd_pkg, bqd_if, the filter RTL and bqd_checker.
module tb_top import bqd_pkg::*; ();

  localparam int SAMPLE_W     = 24;
  localparam int FRAC_W       = 22;
  localparam int STATE_W      = 32;
  localparam int UNITY        = 1 << FRAC_W;
  localparam int A2_LIM       = (UNITY / 10) * 8;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 80;
  localparam int SETTLE_TICKS = 20;   // longer than the filter latency
  localparam int QUIET_LIMIT  = 2000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef enum {SET_STABLE, SET_FIRST_ORDER, SET_SYMMETRIC, SET_RANDOM, SET_EXTREME}
    coef_kind_t;

  localparam sample_t SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam coef_t   COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam sample_t CORNERS [7] = '{
    sample_t'(0), SMP_MAX, SMP_MIN, sample_t'(1), sample_t'(-1),
    sample_t'(24'h555555), sample_t'(24'hAAAAAA)
  };

  logic clk;
  logic rst;
  logic no_idle;
  int   mismatches;
  int   pending;
  int   quiet_cycles;

  bqd_cfg_if                       cfg_bus ();
  bqd_in_if  #(.WIDTH(SAMPLE_W))   in_bus ();
  bqd_out_if #(.WIDTH(SAMPLE_W))   out_bus ();

  biquad_iir_filter #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_W),
    .STATE_WIDTH(STATE_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .in_chan(in_bus),
    .out_chan(out_bus)
  );

  bqd_checker #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_W),
    .STATE_WIDTH(STATE_W)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_mon(cfg_bus),
    .in_mon(in_bus),
    .out_mon(out_bus),
    .mismatches(mismatches),
    .pending(pending)
  );

  // Clock
  always #10 clk = ~clk;

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 23);
  endfunction

  // Output side: random stalls, changed on the falling edge
  always @(negedge clk) begin
    out_bus.ready = !rst && !idle_now();
  end

  // Watchdog: too long without any transfer on a channel ends the run
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("biquad_iir_filter: mismatch");
      $finish;
    end
  end

  function automatic coef_t random_coef_in(input int mag);
    return coef_t'(int'($urandom_range(2 * mag)) - mag);
  endfunction

  function automatic coef_t extreme_coef();
    case ($urandom_range(3))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic coef_set_t pick_coefs(input coef_kind_t kind);
    coef_set_t cs;
    int a2v;
    int a1lim;
    // default: a stable biquad, poles inside the unit circle
    a2v   = int'($urandom_range(2 * A2_LIM)) - A2_LIM;
    a1lim = ((UNITY + a2v) / 10) * 9;
    cs.a2 = coef_t'(a2v);
    cs.a1 = random_coef_in(a1lim);
    cs.b0 = random_coef_in(UNITY / 2);
    cs.b1 = random_coef_in(UNITY);
    cs.b2 = random_coef_in(UNITY / 2);
    case (kind)
      SET_FIRST_ORDER: begin
        cs.a2 = '0;
        cs.b2 = '0;
        cs.a1 = random_coef_in((UNITY / 10) * 9);
      end
      SET_SYMMETRIC: cs.b2 = cs.b0;
      SET_RANDOM: begin
        cs.b0 = coef_t'($urandom);
        cs.b1 = coef_t'($urandom);
        cs.b2 = coef_t'($urandom);
        cs.a1 = coef_t'($urandom);
        cs.a2 = coef_t'($urandom);
      end
      SET_EXTREME: begin
        cs.b0 = extreme_coef();
        cs.b1 = extreme_coef();
        cs.b2 = extreme_coef();
        cs.a1 = extreme_coef();
        cs.a2 = extreme_coef();
      end
      default: ;
    endcase
    return cs;
  endfunction

  // Mostly full-range samples, some small ones, a few corners
  function automatic sample_t random_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return sample_t'($urandom);
    if (roll < 85) return sample_t'(int'($urandom_range(131071)) - 65536);
    case ($urandom_range(4))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      3:       return sample_t'(1);
      default: return sample_t'(-1);
    endcase
  endfunction

  // All tasks below start and end on a falling edge
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic load_coefs(input coef_set_t cs);
    write_coef(REG_FF0, cs.b0);
    write_coef(REG_FF1, cs.b1);
    write_coef(REG_FF2, cs.b2);
    write_coef(REG_FB1, cs.a1);
    write_coef(REG_FB2, cs.a2);
  endtask

  task automatic send_sample(input sample_t value);
    while (idle_now()) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.sample_in = value;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Block idle: every expected sample back, then some settling time
  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    no_idle          = 1'b0;
    quiet_cycles     = 0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // reset coefficients: unity gain passthrough
    foreach (CORNERS[i]) send_sample(CORNERS[i]);
    wait_drained();

    // unmapped indexes must leave the coefficients alone
    for (int idx = int'(REG_FB2) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_coef(CFG_IDX_W'(idx), coef_t'($urandom));
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    wait_drained();

    // runaway feedback: state and output both hit their limits
    load_coefs('{b0: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MIN, a2: COEF_MIN});
    repeat (5) send_sample(SMP_MAX);
    repeat (4) send_sample(SMP_MIN);
    wait_drained();

    // all coefficients at the negative limit
    load_coefs('{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MIN, a2: COEF_MIN});
    repeat (2) send_sample(SMP_MIN);
    repeat (2) send_sample(SMP_MAX);
    wait_drained();

    // all coefficients zero
    load_coefs('0);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);

    // random phases, each with a fresh coefficient set
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      load_coefs(pick_coefs(coef_kind_t'(ph % 5)));
      no_idle = (ph == 3);
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end
    no_idle = 1'b0;
    wait_drained();

    if (mismatches == 0 && pending == 0) begin
      $display("biquad_iir_filter: match");
    end else begin
      $display("biquad_iir_filter: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bqd_pkg.sv
rtl/core/bqd_if.sv
rtl/core/bqd_coef_regs.sv
rtl/core/bqd_mac.sv
rtl/core/bqd_ctrl.sv
rtl/core/biquad_iir_filter.sv
rtl/core/bqd_checker.sv
test/bqd_checker.sv
test/tb_top.sv
